// ===== sv/bps_pkg.sv =====
// Shared types and constants for the byte pattern search core.
// Holds the result record passed from the front to the back, and the field codes.
package bps_pkg;

    localparam int ADDR_W  = 24;
    localparam int LEN_W   = 25;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 10;
    localparam int INDEX_W = 2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [INDEX_W-1:0] REG_START_ADDR   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_SEARCH_LEN   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_SEARCH_VALUE = 2'd2;

    typedef enum logic [1:0] {
        KIND_HIT     = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_SHORT   = 2'd2
    } t_kind;

    // Results caused by one item: an optional hit, then an optional final result.
    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  hit_addr;
        logic [COUNT_W-1:0] hit_cnt;
        logic               hit_cap;
        logic               fin;
        t_kind              fin_kind;
        logic [COUNT_W-1:0] fin_cnt;
        logic               fin_cap;
    } t_rec;

endpackage

// ===== sv/bps_front.sv =====
// Front part of the byte pattern search: configuration registers, window and counters.
// Classifies each accepted item into a result record. Depends on bps_pkg.
module bps_front #(
    parameter int MAX_HITS = 1000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_q_ready,
    output logic                  o_q_push,
    output bps_pkg::t_rec         o_q_data
);
    import bps_pkg::*;

    localparam int CNT_W = $clog2(MAX_HITS + 1);

    logic [ADDR_W-1:0]  r_start_addr;
    logic [LEN_W-1:0]   r_search_len;
    logic [VALUE_W-1:0] r_search_value;
    logic [23:0]        r_window,  n_window;
    logic [LEN_W-1:0]   r_seen,    n_seen;
    logic [CNT_W-1:0]   r_hits,    n_hits;
    logic               r_ovf,     n_ovf;
    logic               r_active,  n_active;

    logic [2:0]         width;
    logic [31:0]        cur;
    logic               eq;
    logic [LEN_W-1:0]   seen_inc;
    logic               done;
    logic               hit;
    logic               take;
    logic [CNT_W-1:0]   hits_inc;
    logic [CNT_W+COUNT_W-1:0] hits_ext;
    logic [CNT_W+COUNT_W-1:0] hits_now_ext;
    t_rec               rec;

    assign o_ready = i_q_ready;
    assign take    = i_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr   <= '0;
            r_search_len   <= '0;
            r_search_value <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_START_ADDR:   r_start_addr   <= i_cfg_data[ADDR_W-1:0];
                REG_SEARCH_LEN:   r_search_len   <= i_cfg_data[LEN_W-1:0];
                REG_SEARCH_VALUE: r_search_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_search_value[31:24] != 8'd0) begin
            width = 3'd4;
        end else if (r_search_value[23:16] != 8'd0) begin
            width = 3'd3;
        end else if (r_search_value[15:8] != 8'd0) begin
            width = 3'd2;
        end else begin
            width = 3'd1;
        end
    end

    assign cur      = {i_data_byte, r_window};
    assign seen_inc = r_seen + LEN_W'(1);
    assign done     = seen_inc >= r_search_len;
    assign hits_inc = r_hits + CNT_W'(1);

    always_comb begin
        unique case (width)
            3'd1:    eq = cur[31:24] == r_search_value[7:0];
            3'd2:    eq = cur[31:16] == r_search_value[15:0];
            3'd3:    eq = cur[31:8]  == r_search_value[23:0];
            default: eq = cur == r_search_value;
        endcase
    end

    assign hit = (seen_inc >= LEN_W'(width)) && eq;

    always_comb begin
        n_window = r_window;
        n_seen   = r_seen;
        n_hits   = r_hits;
        n_ovf    = r_ovf;
        n_active = r_active;
        rec      = '0;
        rec.fin_kind = KIND_SUMMARY;
        if (i_command == CMD_START) begin
            if (r_search_len < LEN_W'(width)) begin
                n_active     = 1'b0;
                rec.fin      = 1'b1;
                rec.fin_kind = KIND_SHORT;
            end else begin
                n_window = '0;
                n_seen   = '0;
                n_hits   = '0;
                n_ovf    = 1'b0;
                n_active = 1'b1;
            end
        end else if (r_active) begin
            n_window = cur[31:8];
            n_seen   = seen_inc;
            if (hit) begin
                if (r_hits < CNT_W'(MAX_HITS)) begin
                    n_hits       = hits_inc;
                    rec.hit      = 1'b1;
                    rec.hit_addr = r_start_addr + seen_inc[ADDR_W-1:0]
                                   - ADDR_W'(width);
                    rec.hit_cnt  = hits_ext[COUNT_W-1:0];
                    rec.hit_cap  = r_ovf;
                end else begin
                    n_ovf = 1'b1;
                end
            end
            if (done) begin
                n_active    = 1'b0;
                rec.fin     = 1'b1;
                rec.fin_cnt = hits_now_ext[COUNT_W-1:0];
                rec.fin_cap = n_ovf;
            end
        end
    end

    assign hits_ext     = {{COUNT_W{1'b0}}, hits_inc};
    assign hits_now_ext = {{COUNT_W{1'b0}}, n_hits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen   <= '0;
            r_hits   <= '0;
            r_ovf    <= 1'b0;
            r_active <= 1'b0;
        end else if (take) begin
            r_window <= n_window;
            r_seen   <= n_seen;
            r_hits   <= n_hits;
            r_ovf    <= n_ovf;
            r_active <= n_active;
        end
    end

    assign o_q_push = take && (rec.hit || rec.fin);
    assign o_q_data = rec;

endmodule

// ===== sv/bps_queue.sv =====
// Short record queue between the front and the back of the pattern search.
// Holds result records so that each side can stall on its own. Depends on bps_pkg.
module bps_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bps_pkg::t_rec i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output bps_pkg::t_rec o_data
);
    import bps_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== sv/bps_back.sv =====
// Back part of the pattern search: takes records from the queue and delivers their
// results one per cycle while i_ready is high, from a held record. Depends on bps_pkg.
module bps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bps_pkg::t_rec i_q_data,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [23:0]   o_hit_address,
    output logic [9:0]    o_hit_count,
    output logic          o_capped,
    output logic          o_last
);
    import bps_pkg::*;

    logic r_busy;
    t_rec r_rec;
    logic take;
    logic final_res;

    assign take      = r_busy && i_ready;
    assign final_res = !r_rec.hit || !r_rec.fin;
    assign o_q_pop   = i_q_valid && (!r_busy || (take && final_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
        end else if (take && final_res) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_data;
        end else if (take) begin
            r_rec.hit <= 1'b0;
        end
    end

    assign o_valid = r_busy;

    always_comb begin
        if (r_rec.hit) begin
            o_kind        = KIND_HIT;
            o_hit_address = r_rec.hit_addr;
            o_hit_count   = r_rec.hit_cnt;
            o_capped      = r_rec.hit_cap;
            o_last        = !r_rec.fin;
        end else begin
            o_kind        = r_rec.fin_kind;
            o_hit_address = '0;
            o_hit_count   = r_rec.fin_cnt;
            o_capped      = r_rec.fin_cap;
            o_last        = 1'b1;
        end
    end

endmodule

// ===== sv/byte_pattern_search_core.sv =====
// Top level of the byte pattern search core: front, record queue and back.
// Depends on bps_pkg, bps_front, bps_queue and bps_back.
//
// The core takes one item per cycle, a start command or a memory byte, and
// compares the last one to four bytes in parallel with the search value, so a
// byte stream is scanned at one byte per clock. Results leave one per cycle
// while the receiver is ready; a byte that both hits and ends the range yields
// two results, which the two-entry record queue between the front and the back
// absorbs. The input stalls only while that queue is full. Hit counts
// saturate at MAX_HITS and are reported in ten bits.
module byte_pattern_search_core #(
    parameter int MAX_HITS = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [23:0] o_hit_address,
    output logic [9:0]  o_hit_count,
    output logic        o_capped,
    output logic        o_last
);
    import bps_pkg::*;

    logic q_ready;
    logic q_push;
    t_rec q_in;
    logic q_pop;
    logic q_valid;
    t_rec q_out;

    bps_front #(
        .MAX_HITS (MAX_HITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_q_ready   (q_ready),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    bps_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    bps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_hit_address (o_hit_address),
        .o_hit_count   (o_hit_count),
        .o_capped      (o_capped),
        .o_last        (o_last)
    );

endmodule

// ===== sv/bps_checker.sv =====
// Port-level checks for the byte pattern search core, bound to the top level.
// Depends on bps_pkg and byte_pattern_search_core.
module bps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [23:0] o_hit_address,
    input logic [9:0]  o_hit_count,
    input logic        o_capped,
    input logic        o_last
);
    import bps_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_hit_address)
            && $stable(o_hit_count) && $stable(o_capped) && $stable(o_last))
        else $error("Stalled result changed.");

    a_hit_then_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_kind == KIND_HIT && !o_last
            |=> o_valid && o_kind == KIND_SUMMARY && o_last)
        else $error("Hit not followed by its summary.");

    a_final_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_HIT |-> o_last && o_hit_address == 24'd0)
        else $error("Summary or short result with bad fields.");

    a_short_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_SHORT |-> o_hit_count == 10'd0 && !o_capped)
        else $error("Short-range result carries counts.");

endmodule

bind byte_pattern_search_core bps_checker u_bps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_hit_address (o_hit_address),
    .o_hit_count   (o_hit_count),
    .o_capped      (o_capped),
    .o_last        (o_last)
);

// ===== test/tb_byte_pattern_search_core.sv =====
// Self-checking testbench for byte_pattern_search_core: directed rows, a capped search,
// a stalled-output stretch and random searches, scored against an in-bench predictor
// or typed expectations. Depends on bps_pkg and the RTL of the core only.
module tb_byte_pattern_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam int MAX_HITS      = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 250;
    localparam int RANDOM_ITEMS  = 100;
    localparam int PREDICTED     = -1;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  count;
        logic                capped;
        logic                last;
    } t_report;

    typedef struct packed {
        logic       typed;
        logic [1:0] n_typed;
        t_report    r0;
        t_report    r1;
    } t_item_note;

    typedef struct packed {
        logic               is_cfg;
        logic [INDEX_W-1:0] index;
        logic [31:0]        value;
        logic               cmd;
        logic [7:0]         data;
        t_item_note         note;
    } t_step_row;

    localparam t_report NO_REP = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [23:0] o_hit_address;
    logic [9:0]  o_hit_count;
    logic        o_capped;
    logic        o_last;

    byte_pattern_search_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_hit_address (o_hit_address),
        .o_hit_count   (o_hit_count),
        .o_capped      (o_capped),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    logic [ADDR_W-1:0]  cfg_base    = '0;
    logic [LEN_W-1:0]   cfg_len     = '0;
    logic [VALUE_W-1:0] cfg_pattern = '0;
    logic [23:0]        win         = '0;
    logic [LEN_W-1:0]   seen        = '0;
    logic [COUNT_W-1:0] n_hits      = '0;
    logic               overflow    = 1'b0;
    logic               active      = 1'b0;

    t_report     due_reports[$];
    t_item_note  item_notes[$];
    t_step_row   dir_rows[$];
    logic [7:0]  byte_backlog[$];

    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_idle_pct  = 0;
    logic        hold_receiver = 1'b0;
    int unsigned mismatches    = 0;
    int unsigned items_taken   = 0;
    int unsigned hits_seen     = 0;
    int unsigned ends_seen     = 0;
    int unsigned shorts_seen   = 0;
    int unsigned scan_items    = 0;
    int unsigned searches      = 0;

    function automatic int unsigned pattern_bytes(input logic [31:0] v);
        if (v[31:24] != 8'd0) return 4;
        if (v[23:16] != 8'd0) return 3;
        if (v[15:8] != 8'd0) return 2;
        return 1;
    endfunction

    function automatic t_report rep(input t_kind k, input logic [23:0] a,
                                    input logic [9:0] c, input logic cap, input logic last);
        t_report r;
        r.kind   = k;
        r.addr   = a;
        r.count  = c;
        r.capped = cap;
        r.last   = last;
        return r;
    endfunction

    function automatic t_step_row row_cfg(input logic [INDEX_W-1:0] idx, input logic [31:0] val);
        t_step_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.index  = idx;
        r.value  = val;
        return r;
    endfunction

    function automatic t_step_row row_item(input logic cmd, input logic [7:0] b, input int n,
                                           input t_report r0, input t_report r1);
        t_step_row r;
        r = '0;
        r.cmd           = cmd;
        r.data          = b;
        r.note.typed    = (n != PREDICTED);
        r.note.n_typed  = (n == PREDICTED) ? 2'd0 : 2'(n);
        r.note.r0       = r0;
        r.note.r1       = r1;
        return r;
    endfunction

    // Advances the search state by one item and returns the reports it produces.
    task automatic scan_predict(input logic cmd, input logic [7:0] b,
                                output int n, output t_report r0, output t_report r1);
        int unsigned w;
        logic [31:0] cur;
        logic [31:0] mask;
        logic [31:0] at;
        logic        done;
        logic        hit;
        t_report     outs [2];
        w = pattern_bytes(cfg_pattern);
        n = 0;
        outs[0] = NO_REP;
        outs[1] = NO_REP;
        if (cmd == CMD_START) begin
            if (cfg_len < w) begin
                active = 1'b0;
                outs[n++] = rep(KIND_SHORT, 24'd0, 10'd0, 1'b0, 1'b1);
            end else begin
                win      = '0;
                seen     = '0;
                n_hits   = '0;
                overflow = 1'b0;
                active   = 1'b1;
            end
        end else if (active) begin
            cur  = {b, win};
            mask = (w == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * w)) - 32'd1);
            win  = cur[31:8];
            seen = seen + 25'd1;
            done = (seen >= cfg_len);
            hit  = (seen >= w) && (((cur >> (8 * (4 - w))) & mask) == (cfg_pattern & mask));
            if (hit) begin
                if (n_hits < MAX_HITS) begin
                    n_hits    = n_hits + 10'd1;
                    at        = 32'(cfg_base) + 32'(seen) - w;
                    outs[n++] = rep(KIND_HIT, at[23:0], n_hits, overflow, !done);
                end else begin
                    overflow = 1'b1;
                end
            end
            if (done) begin
                active    = 1'b0;
                outs[n++] = rep(KIND_SUMMARY, 24'd0, n_hits, overflow, 1'b1);
            end
        end
        r0 = outs[0];
        r1 = outs[1];
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_item_note note;
        t_report    r0;
        t_report    r1;
        t_report    want;
        int         n;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                items_taken++;
                note = (item_notes.size() != 0) ? item_notes.pop_front() : '0;
                scan_predict(i_command, i_data_byte, n, r0, r1);
                if (note.typed) begin
                    n  = note.n_typed;
                    r0 = note.r0;
                    r1 = note.r1;
                end
                if (n > 0) due_reports.push_back(r0);
                if (n > 1) due_reports.push_back(r1);
            end
            if (o_valid && i_ready) begin
                if (due_reports.size() == 0) begin
                    $error("result with no expectation: kind %0d, address %0h, count %0d",
                           o_kind, o_hit_address, o_hit_count);
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(o_kind));
                    compare_field("hit_address", 32'(want.addr), 32'(o_hit_address));
                    compare_field("hit_count", 32'(want.count), 32'(o_hit_count));
                    compare_field("capped", 32'(want.capped), 32'(o_capped));
                    compare_field("last", 32'(want.last), 32'(o_last));
                    case (want.kind)
                        KIND_HIT:     hits_seen++;
                        KIND_SUMMARY: ends_seen++;
                        default:      shorts_seen++;
                    endcase
                end
            end
        end
    end

    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_receiver) begin
                hold_receiver = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b, input t_item_note note);
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        item_notes.push_back(note);
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_scan(input logic cmd, input logic [7:0] b);
        send_item(cmd, b, '0);
        scan_items++;
    endtask

    task automatic drain_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_START_ADDR:   cfg_base    = val[ADDR_W-1:0];
            REG_SEARCH_LEN:   cfg_len     = val[LEN_W-1:0];
            REG_SEARCH_VALUE: cfg_pattern = val;
            default:          ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic setup_search(input logic [23:0] base, input logic [24:0] len,
                                input logic [31:0] val);
        drain_block();
        write_reg(REG_START_ADDR, 32'(base));
        write_reg(REG_SEARCH_LEN, 32'(len));
        write_reg(REG_SEARCH_VALUE, val);
    endtask

    function automatic logic [7:0] next_scan_byte(input int unsigned w, input logic [31:0] val);
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(99);
        if (byte_backlog.size() == 0) begin
            if (roll < 40) begin
                for (int k = 0; k < w; k++) byte_backlog.push_back(val[8*k +: 8]);
            end else if (roll < 55) begin
                span = $urandom_range(1, w);
                for (int k = 0; k < span; k++) byte_backlog.push_back(val[8*k +: 8]);
            end else begin
                byte_backlog.push_back(8'($urandom));
            end
        end
        return byte_backlog.pop_front();
    endfunction

    task automatic random_search();
        int unsigned w;
        int unsigned shape;
        int unsigned feed;
        int unsigned lead;
        logic [31:0] val;
        logic [7:0]  top;
        logic [24:0] len;
        logic [23:0] base;
        w   = $urandom_range(1, 4);
        top = 8'($urandom_range(1, 255));
        val = ($urandom_range(3) == 0) ? {4{top}} : $urandom;
        case (w)
            1:       val = {24'd0, val[7:0]};
            2:       val = {16'd0, top, val[7:0]};
            3:       val = {8'd0, top, val[15:0]};
            default: val = {top, val[23:0]};
        endcase
        base  = ($urandom_range(3) == 0) ? 24'hFFFFFF - 24'($urandom_range(0, 40))
                                         : 24'($urandom);
        shape = $urandom_range(99);
        if (shape < 8) begin
            len  = 25'($urandom_range(0, w - 1));
            feed = 0;
        end else if (shape < 14) begin
            len  = 25'($urandom_range(64, 16777216));
            feed = $urandom_range(5, 40);
        end else begin
            len  = 25'($urandom_range(w, 40));
            feed = len;
        end
        setup_search(base, len, val);
        searches++;
        byte_backlog.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(CMD_DATA, 8'($urandom), '0);
        end
        send_scan(CMD_START, 8'($urandom));
        if (feed != 0) begin
            if ($urandom_range(99) < 8) begin
                lead = $urandom_range(0, feed - 1);
                repeat (lead) send_scan(CMD_DATA, next_scan_byte(w, val));
                send_scan(CMD_START, 8'($urandom));
                byte_backlog.delete();
            end
            if ($urandom_range(99) < 8) feed = $urandom_range(0, feed - 1);
            repeat (feed) send_scan(CMD_DATA, next_scan_byte(w, val));
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 2)) send_item(CMD_DATA, 8'($urandom), '0);
        end
    endtask

    initial begin : watchdog
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        t_item_note note;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_START_ADDR;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_command   <= CMD_START;
        i_data_byte <= '0;
        dir_rows = '{
            row_item(CMD_DATA, 8'hFF, 0, NO_REP, NO_REP),
            row_item(CMD_START, 8'h00, 1, rep(KIND_SHORT, 24'd0, 10'd0, 1'b0, 1'b1), NO_REP),
            row_cfg(REG_START_ADDR, 32'h00FF_FFFE),
            row_cfg(REG_SEARCH_LEN, 32'd3),
            row_cfg(REG_SEARCH_VALUE, 32'h0000_00FF),
            row_item(CMD_START, 8'h00, 0, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'hFF, 1, rep(KIND_HIT, 24'hFFFFFE, 10'd1, 1'b0, 1'b1), NO_REP),
            row_item(CMD_DATA, 8'h00, 0, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'hFF, 2, rep(KIND_HIT, 24'h000000, 10'd2, 1'b0, 1'b0),
                     rep(KIND_SUMMARY, 24'd0, 10'd2, 1'b0, 1'b1)),
            row_item(CMD_DATA, 8'h5A, 0, NO_REP, NO_REP),
            row_cfg(REG_SEARCH_VALUE, 32'hFFFF_FFFF),
            row_item(CMD_START, 8'hFF, 1, rep(KIND_SHORT, 24'd0, 10'd0, 1'b0, 1'b1), NO_REP),
            row_cfg(REG_SEARCH_LEN, 32'd16777216),
            row_cfg(REG_START_ADDR, 32'd0),
            row_item(CMD_START, 8'h00, 0, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'hFF, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'hFF, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'hFF, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'hFF, PREDICTED, NO_REP, NO_REP),
            row_cfg(REG_SEARCH_VALUE, 32'h00FF_FFFF),
            row_item(CMD_DATA, 8'hFF, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'hFF, PREDICTED, NO_REP, NO_REP),
            row_cfg(REG_SEARCH_VALUE, 32'h0000_0100),
            row_cfg(REG_SEARCH_LEN, 32'd2),
            row_cfg(REG_START_ADDR, 32'h0012_3456),
            row_item(CMD_START, 8'h00, 0, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h01, 0, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h00, 1, rep(KIND_SUMMARY, 24'd0, 10'd0, 1'b0, 1'b1), NO_REP),
            row_cfg(REG_SEARCH_VALUE, 32'h0001_0000),
            row_cfg(REG_SEARCH_LEN, 32'd4),
            row_item(CMD_START, 8'h00, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h00, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h00, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_START, 8'h00, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h00, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h00, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h01, PREDICTED, NO_REP, NO_REP),
            row_item(CMD_DATA, 8'h7F, PREDICTED, NO_REP, NO_REP),
            row_cfg(REG_SEARCH_VALUE, 32'h0000_FFFF),
            row_cfg(REG_SEARCH_LEN, 32'd1),
            row_item(CMD_START, 8'h00, 1, rep(KIND_SHORT, 24'd0, 10'd0, 1'b0, 1'b1), NO_REP)
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 15;
        rcv_idle_pct = 52;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain_block();
                write_reg(dir_rows[i].index, dir_rows[i].value);
            end else begin
                note = dir_rows[i].note;
                send_item(dir_rows[i].cmd, dir_rows[i].data, note);
            end
        end

        // More than MAX_HITS matches in one range, with a match on the final byte.
        snd_idle_pct = 52;
        rcv_idle_pct = 15;
        setup_search(24'($urandom), 25'd1004, 32'h0000_00A5);
        send_item(CMD_START, 8'h00, '0);
        for (int k = 0; k < 1004; k++) begin
            send_item(CMD_DATA, (k == 300 || k == 777) ? 8'h5A : 8'hA5, '0);
        end

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        setup_search(24'hFFFFF0, 25'd60, 32'h0000_003C);
        hold_receiver = 1'b1;
        send_item(CMD_START, 8'h00, '0);
        repeat (60) send_item(CMD_DATA, 8'h3C, '0);

        scan_items = 0;
        while (scan_items < RANDOM_ITEMS) begin
            random_search();
        end

        drain_block();
        repeat (20) @(posedge i_clk);
        $display("Scanned %0d items over %0d random searches plus directed and capped ranges.",
                 items_taken, searches);
        $display("Checked %0d hits, %0d end summaries, %0d short-range errors; %0d mismatches.",
                 hits_seen, ends_seen, shorts_seen, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bps_pkg.sv
sv/bps_front.sv
sv/bps_queue.sv
sv/bps_back.sv
sv/byte_pattern_search_core.sv
sv/bps_checker.sv
test/tb_byte_pattern_search_core.sv
